// ===== rtl/pfa_pkg.sv =====
package pfa_pkg;

  localparam int MAX_BLOCKS_DEF = 32;
  localparam int SIZE_BITS_DEF  = 16;

  // fixed widths of the item fields
  localparam int IDX_FW   = 5;
  localparam int AMT_FW   = 16;
  localparam int BCNT_FW  = 6;
  localparam int POL_FW   = 2;

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_FIRST = 2'd1;
  localparam logic [1:0] FIT_NEXT  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  localparam logic [BCNT_FW-1:0] BLOCK_COUNT_RST = BCNT_FW'(32);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [POL_FW-1:0]  policy;
    logic [BCNT_FW-1:0] bcount;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [IDX_FW-1:0] load_index;
    logic [AMT_FW-1:0] amount;
    logic              batch_end;
  } item_t;

  typedef struct packed {
    logic              granted;
    logic [IDX_FW-1:0] chosen_block;
    logic [AMT_FW-1:0] remaining;
    logic              last_result;
  } res_t;

endpackage

// ===== rtl/pfa_ram.sv =====
module pfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/pfa_engine.sv =====
module pfa_engine
  import pfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (SIZE_BITS > AMT_FW) ? SIZE_BITS : AMT_FW;

  state_t state_r, state_nxt;

  logic [IW-1:0]        np_r;
  logic [IW-1:0]        pos_r;
  logic [CW-1:0]        iss_r;
  logic                 rd_vld_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 found_r;
  logic [IW-1:0]        pick_r;
  logic [SIZE_BITS-1:0] best_r;
  item_t                item_r;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;

  logic [CW-1:0]        cnt;
  logic [CW-1:0]        pos_inc;
  logic [IW-1:0]        pos_step;
  logic [IW-1:0]        start_pos;
  logic [CMPW-1:0]      in_amt_w;
  logic [CMPW-1:0]      size_max_w;
  logic [SIZE_BITS-1:0] load_val;
  logic                 load_ok;
  logic                 accept;
  logic                 reply_done;
  logic                 fits;
  logic                 take;
  logic [SIZE_BITS-1:0] left_val;

  pfa_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(MAX_BLOCKS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pos_r),
    .rdata(ram_rdata)
  );

  // blocks in use, clamped to the table depth
  assign cnt = (32'(cfg.bcount) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(cfg.bcount);

  assign start_pos = ((cfg.policy == FIT_NEXT) && (CW'(np_r) < cnt)) ? np_r : '0;
  assign pos_inc   = CW'(pos_r) + CW'(1);
  assign pos_step  = (pos_inc == cnt) ? '0 : IW'(pos_inc);

  assign in_amt_w   = CMPW'(in_item.amount);
  assign size_max_w = CMPW'({SIZE_BITS{1'b1}});
  assign load_val   = (in_amt_w > size_max_w) ? SIZE_BITS'(size_max_w) : SIZE_BITS'(in_amt_w);
  assign load_ok    = 32'(in_item.load_index) < 32'(MAX_BLOCKS);

  assign accept     = in_valid && in_ready;
  assign reply_done = res_valid && res_ready;

  // scan compare on the entry returned this cycle
  assign fits = CMPW'(ram_rdata) >= CMPW'(item_r.amount);
  always_comb begin
    take = 1'b0;
    if (rd_vld_r && fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (cfg.policy == FIT_BEST) begin
        take = ram_rdata < best_r;
      end else if (cfg.policy == FIT_WORST) begin
        take = ram_rdata > best_r;
      end
    end
  end

  assign left_val = best_r - SIZE_BITS'(item_r.amount);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.func == FUNC_ALLOC && cnt != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_REPLY;
          end
        end
      end
      ST_SCAN: begin
        if (iss_r == cnt - CW'(1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST:  state_nxt = ST_REPLY;
      ST_REPLY: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and table write port
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pick_r;
    ram_wdata = left_val;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_we    = in_valid && in_item.func == FUNC_LOAD && load_ok;
        ram_waddr = IW'(in_item.load_index);
        ram_wdata = load_val;
      end
      ST_REPLY: begin
        res_valid = 1'b1;
        ram_we    = res_ready && found_r && item_r.func == FUNC_ALLOC;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.granted      = found_r;
    res.chosen_block = found_r ? IDX_FW'(pick_r) : '0;
    res.remaining    = '0;
    if (found_r) begin
      res.remaining = (item_r.func == FUNC_ALLOC) ? AMT_FW'(left_val) : AMT_FW'(best_r);
    end
    res.last_result  = item_r.batch_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      np_r     <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN);
      if (accept) begin
        found_r <= (in_item.func == FUNC_LOAD) && load_ok;
        if (in_item.func == FUNC_LOAD && load_ok) begin
          np_r <= '0;
        end
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (reply_done && item_r.func == FUNC_ALLOC) begin
        if (item_r.batch_end) begin
          np_r <= '0;
        end else if (found_r && cfg.policy == FIT_NEXT) begin
          np_r <= pick_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= pos_r;
    if (accept) begin
      item_r <= in_item;
      pos_r  <= start_pos;
      iss_r  <= '0;
      pick_r <= IW'(in_item.load_index);
      best_r <= load_val;
    end else begin
      if (state_r == ST_SCAN) begin
        pos_r <= pos_step;
        iss_r <= iss_r + CW'(1);
      end
      if (take) begin
        pick_r <= rd_idx_r;
        best_r <= ram_rdata;
      end
    end
  end

`ifndef SYNTH
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_LAST) |-> !ram_we)
    else $error("table written during a scan");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r < cnt))
    else $error("scan issued beyond block count");

  a_pick_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLY && found_r && item_r.func == FUNC_ALLOC)
      |-> (CW'(pick_r) < cnt))
    else $error("chosen block outside blocks in use");

  a_batch_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (reply_done && item_r.func == FUNC_ALLOC && item_r.batch_end) |=> (np_r == '0))
    else $error("next position not rewound at end of batch");
`endif

endmodule

// ===== rtl/partition_fit_allocator_core.sv =====
// partition fit allocator: keeps a table of free block sizes and serves
// load and allocation items under a best, first, next or worst fit policy.
// input channel in_*: tuser = func, tlast = batch_end,
//   tdata = load_index, amount. one result item per input item.
// output channel out_*: tuser = granted, tlast = last_result,
//   tdata = chosen_block, remaining.
// cfg_* is an apb-style port: fit_policy at 0x0, block_count at 0x4;
//   write only while no item is in flight.
// a load goes from acceptance straight to the reply state; a request first passes
//   the scan and last states (both are skipped when n is zero), n
//   being block_count clamped to MAX_BLOCKS, as the single read port of the
//   table is swept one entry per cycle. the next item is taken only after
//   the reply has entered the output register, so one item is served at a time.
// a finished result waits in the output register while out_tready stays low;
//   with the output register still full the block holds its next result and
//   takes no further item until out_tready frees it.
// reset clears the policy to best fit, block_count to 32 and the next-fit
//   position to 0; the size table is not cleared and every entry must be
//   loaded before a request reads it.
module partition_fit_allocator_core
  import pfa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // [4:0] load_index, [20:5] amount, rest zero
  input  logic              in_tuser,   // [0] func
  input  logic              in_tlast,

  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,  // [4:0] chosen_block, [20:5] remaining, rest zero
  output logic              out_tuser,  // [0] granted
  output logic              out_tlast,

  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg_r;
  item_t in_item;
  res_t  res;
  res_t  out_res_r;
  logic  out_tvalid_r;
  logic  res_valid;
  logic  res_ready;
  logic  cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy <= FIT_BEST;
      cfg_r.bcount <= BLOCK_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_FIT_POLICY:  cfg_r.policy <= cfg_pwdata[POL_FW-1:0];
        REG_BLOCK_COUNT: cfg_r.bcount <= cfg_pwdata[BCNT_FW-1:0];
        default:         cfg_r.policy <= cfg_r.policy;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      REG_FIT_POLICY:  cfg_prdata = CFG_DW'(cfg_r.policy);
      REG_BLOCK_COUNT: cfg_prdata = CFG_DW'(cfg_r.bcount);
      default:         cfg_prdata = '0;
    endcase
  end

  assign in_item.func       = in_tuser;
  assign in_item.load_index = in_tdata[IDX_FW-1:0];
  assign in_item.amount     = in_tdata[IDX_FW+AMT_FW-1:IDX_FW];
  assign in_item.batch_end  = in_tlast;

  pfa_engine #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // output register parts the engine from the receiver
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_res_r.remaining, out_res_r.chosen_block};
  assign out_tuser  = out_res_r.granted;
  assign out_tlast  = out_res_r.last_result;

endmodule

// ===== tb/partition_fit_allocator_core_tb.sv =====
module partition_fit_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  logic                clk;
  logic                rst_n       = 1'b0;

  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [23:0]         in_tdata    = '0;  // [4:0] load_index, [20:5] amount, rest zero
  logic                in_tuser    = 1'b0; // [0] func
  logic                in_tlast    = 1'b0;

  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [23:0]         out_tdata;         // [4:0] chosen_block, [20:5] remaining, rest zero
  logic                out_tuser;         // [0] granted
  logic                out_tlast;

  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr   = '0;
  logic [CFG_DW-1:0]   cfg_pwdata  = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  partition_fit_allocator_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  typedef struct {
    bit          is_cfg;
    logic        reg_sel;
    logic [31:0] value;
    item_t       it;
    bit          typed;
    res_t        want;
  } step_t;

  // allocator state as the testbench sees it
  logic [AMT_FW-1:0]  free_table [MAX_BLOCKS_DEF];
  logic [IDX_FW-1:0]  next_slot  = '0;
  logic [POL_FW-1:0]  fit_mode   = FIT_BEST;
  logic [BCNT_FW-1:0] blocks_cfg = BLOCK_COUNT_RST;

  res_t  awaited_results [$];
  step_t plan [$];
  int    errors   = 0;
  bit    tx_quiet = 1'b0;
  bit    rx_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic res_t predict_allocation(item_t it);
    res_t r;
    int   n;
    int   pick;
    int   pos;
    int   k;
    r = '0;
    r.last_result = it.batch_end;
    if (it.func == FUNC_LOAD) begin
      free_table[it.load_index] = it.amount;
      next_slot = '0;
      r.granted = 1'b1;
      r.chosen_block = it.load_index;
      r.remaining = it.amount;
    end else begin
      n = (blocks_cfg > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(blocks_cfg);
      pick = -1;
      if (fit_mode == FIT_NEXT) begin
        // one full circle from the saved position, stale position restarts at 0
        pos = (next_slot < n) ? int'(next_slot) : 0;
        for (k = 0; k < n; k++) begin
          if (pick < 0 && free_table[pos] >= it.amount) pick = pos;
          pos = (pos + 1 == n) ? 0 : pos + 1;
        end
      end else begin
        for (k = 0; k < n; k++) begin
          if (free_table[k] >= it.amount) begin
            if (pick < 0) pick = k;
            else if (fit_mode == FIT_BEST && free_table[k] < free_table[pick]) pick = k;
            else if (fit_mode == FIT_WORST && free_table[k] > free_table[pick]) pick = k;
          end
        end
      end
      if (pick >= 0) begin
        free_table[pick] = free_table[pick] - it.amount;
        if (fit_mode == FIT_NEXT) next_slot = IDX_FW'(pick);
        r.granted = 1'b1;
        r.chosen_block = IDX_FW'(pick);
        r.remaining = free_table[pick];
      end
      if (it.batch_end) next_slot = '0;
    end
    return r;
  endfunction

  function automatic step_t cfg_step(logic sel, logic [31:0] v);
    step_t s;
    s.is_cfg = 1'b1;
    s.reg_sel = sel;
    s.value = v;
    s.it = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t item_step(logic fn, int idx, int amt, bit last);
    step_t s;
    s.is_cfg = 1'b0;
    s.reg_sel = 1'b0;
    s.value = '0;
    s.it.func = fn;
    s.it.load_index = IDX_FW'(idx);
    s.it.amount = AMT_FW'(amt);
    s.it.batch_end = last;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t typed_step(logic fn, int idx, int amt, bit last,
                                       bit g, int blk, int rem);
    step_t s;
    s = item_step(fn, idx, amt, last);
    s.typed = 1'b1;
    s.want.granted = g;
    s.want.chosen_block = IDX_FW'(blk);
    s.want.remaining = AMT_FW'(rem);
    s.want.last_result = last;
    return s;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.func = ($urandom_range(0, 9) < 3) ? FUNC_LOAD : FUNC_ALLOC;
    it.load_index = IDX_FW'($urandom_range(0, MAX_BLOCKS_DEF - 1));
    it.batch_end = ($urandom_range(0, 5) == 0);
    if (it.func == FUNC_LOAD) begin
      case ($urandom_range(0, 9))
        0:       it.amount = '1;
        1:       it.amount = '0;
        2, 3:    it.amount = AMT_FW'($urandom);
        default: it.amount = AMT_FW'($urandom_range(0, 4000));
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0:       it.amount = '0;
        1:       it.amount = '1;
        2:       it.amount = AMT_FW'($urandom);
        default: it.amount = AMT_FW'($urandom_range(1, 1500));
      endcase
    end
    return it;
  endfunction

  task automatic cfg_write(logic sel, logic [31:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_AW'(4 * sel);
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (sel == REG_FIT_POLICY) fit_mode = v[POL_FW-1:0];
    else blocks_cfg = v[BCNT_FW-1:0];
  endtask

  // valid is left high after acceptance so back-to-back items need no toggle
  task automatic issue_item(item_t it, bit typed, res_t want);
    int   gap;
    res_t model_res;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, it.amount, it.load_index};
    in_tuser <= it.func;
    in_tlast <= it.batch_end;
    do @(posedge clk); while (!in_tready);
    model_res = predict_allocation(it);
    awaited_results.push_back(typed ? want : model_res);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
    end
  endtask

  // result side
  initial begin
    int   stall;
    res_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (awaited_results.size() == 0) begin
        errors++;
        $error("result item with nothing expected: tdata %h", out_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("granted", 32'(want.granted), 32'(out_tuser));
        check_field("chosen_block", 32'(want.chosen_block), 32'(out_tdata[4:0]));
        check_field("remaining", 32'(want.remaining), 32'(out_tdata[20:5]));
        check_field("last_result", 32'(want.last_result), 32'(out_tlast));
      end
    end
  end

  initial begin
    item_t       it;
    int          p;
    int          n;
    logic [31:0] bc;

    // four blocks only, so every entry read is loaded first
    plan.push_back(cfg_step(REG_BLOCK_COUNT, 4));
    plan.push_back(typed_step(FUNC_LOAD,  0, 'h0010, 0, 1, 0, 'h0010));
    plan.push_back(typed_step(FUNC_LOAD,  1, 'hFFFF, 0, 1, 1, 'hFFFF));
    plan.push_back(typed_step(FUNC_LOAD,  2, 'h0008, 0, 1, 2, 'h0008));
    plan.push_back(typed_step(FUNC_LOAD,  3, 'h0020, 1, 1, 3, 'h0020));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0008, 0));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0000, 0));  // zero request on an empty block
    plan.push_back(item_step(FUNC_ALLOC, 31, 'hFFFF, 0));
    plan.push_back(typed_step(FUNC_ALLOC, 0, 'hFFFF, 0, 0, 0, 0));
    plan.push_back(cfg_step(REG_FIT_POLICY, 32'(FIT_WORST)));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0001, 0));
    plan.push_back(cfg_step(REG_FIT_POLICY, 32'(FIT_FIRST)));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0005, 0));
    plan.push_back(cfg_step(REG_FIT_POLICY, 32'(FIT_NEXT)));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0004, 0));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0010, 0));
    // saved position now beyond the count
    plan.push_back(cfg_step(REG_BLOCK_COUNT, 2));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0001, 0));
    plan.push_back(cfg_step(REG_BLOCK_COUNT, 4));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h000E, 0));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0001, 1));
    plan.push_back(item_step(FUNC_ALLOC,  0, 'h0001, 0));
    plan.push_back(cfg_step(REG_BLOCK_COUNT, 0));
    plan.push_back(typed_step(FUNC_ALLOC, 0, 'h0000, 1, 0, 0, 0));
    plan.push_back(cfg_step(REG_BLOCK_COUNT, 1));
    plan.push_back(item_step(FUNC_ALLOC, 21, 'h0003, 1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        cfg_write(plan[i].reg_sel, plan[i].value);
      end else begin
        issue_item(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    // fill the whole table before any wider search
    wait_idle();
    cfg_write(REG_BLOCK_COUNT, 32);
    for (n = 0; n < MAX_BLOCKS_DEF; n++) begin
      it = random_item();
      it.func = FUNC_LOAD;
      it.load_index = IDX_FW'(n);
      if (n == MAX_BLOCKS_DEF - 1) it.amount = '1;
      issue_item(it, 1'b0, '0);
    end

    for (p = 0; p < 12; p++) begin
      wait_idle();
      case (p)
        0:       bc = 32;
        1:       bc = 63;
        2:       bc = 1;
        3:       bc = $urandom_range(33, 62);
        4:       bc = 0;
        default: bc = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4)
                                                   : $urandom_range(5, 32);
      endcase
      cfg_write(REG_FIT_POLICY, (p < 4) ? p : $urandom_range(0, 3));
      cfg_write(REG_BLOCK_COUNT, bc);
      tx_quiet = (p % 4 == 1) || ($urandom_range(0, 4) == 0);
      rx_quiet = (p % 4 == 2) || ($urandom_range(0, 4) == 0);
      for (n = 0; n < 68; n++) begin
        issue_item(random_item(), 1'b0, '0);
        if (n == 34 && p % 3 == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (2 * MAX_BLOCKS_DEF + 10) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
